// ===== rtl/core/rde_pkg.sv =====
// ----------------------------------------------------------------------------
// rde_pkg: shared types and constants of the radix digit emitter
// Register indexes, back-end states, result item layout and queue depths.
// ----------------------------------------------------------------------------
package rde_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE_LENGTH  = 2'd0,
    CFG_SYMBOLS_LOW  = 2'd1,
    CFG_SYMBOLS_HIGH = 2'd2
  } cfg_index_t;

  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 64;
  localparam int RADIX_W       = 5;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;

  localparam int DIGIT_W       = 4;
  localparam int SYMBOL_W      = 8;
  localparam int CHUNK_BITS    = 8;   // dividend bits consumed per cycle

  localparam int IN_DEPTH      = 2;   // front-to-back queue
  localparam int OUT_DEPTH     = 4;   // result queue

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } back_state_t;

  // One result item
  typedef struct packed {
    logic                last;
    logic [SYMBOL_W-1:0] symbol;
  } out_item_t;

endpackage

// ===== rtl/core/rde_ram.sv =====
// ----------------------------------------------------------------------------
// rde_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rde_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rde_fifo.sv =====
// ----------------------------------------------------------------------------
// rde_fifo: small register queue
// Circular buffer with occupancy count; push and pop in the same cycle.
// ----------------------------------------------------------------------------
module rde_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           push_data,
  input  logic                       pop,
  output logic [WIDTH-1:0]           pop_data,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wptr] <= push_data;
    end
  end

endmodule

// ===== rtl/core/rde_front.sv =====
// ----------------------------------------------------------------------------
// rde_front: input stage
// Masks the value to VALUE_WIDTH bits and turns negative signed values into
// their magnitude before queueing.
// ----------------------------------------------------------------------------
module rde_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   in_valid,
  input  logic [63:0]            in_value,
  input  logic                   in_signed,
  input  logic                   q_full,
  output logic                   in_ready,
  output logic                   q_push,
  output logic [VALUE_WIDTH-1:0] q_data
);

  logic [VALUE_WIDTH-1:0] raw;

  assign raw      = in_value[VALUE_WIDTH-1:0];
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Two's complement negate covers the most negative value exactly
  always_comb begin
    if (in_signed && raw[VALUE_WIDTH-1]) begin
      q_data = ~raw + VALUE_WIDTH'(1);
    end else begin
      q_data = raw;
    end
  end

endmodule

// ===== rtl/core/rde_back.sv =====
// ----------------------------------------------------------------------------
// rde_back: divider and digit emitter
// Long division by the radix, eight dividend bits per cycle; digits go to a
// RAM, then are read back most significant first into the result queue.
// ----------------------------------------------------------------------------
module rde_back #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [rde_pkg::RADIX_W-1:0]         radix,
  input  logic [rde_pkg::SYMBOL_W-1:0]        sym_tab [MAX_SYMBOLS],
  input  logic                                item_valid,
  input  logic [VALUE_WIDTH-1:0]              item_value,
  output logic                                item_pop,
  input  logic [$clog2(rde_pkg::OUT_DEPTH+1)-1:0] out_count,
  output logic                                out_push,
  output rde_pkg::out_item_t                  out_item
);

  localparam int STEPS = (VALUE_WIDTH + rde_pkg::CHUNK_BITS - 1) / rde_pkg::CHUNK_BITS;
  localparam int PADW  = STEPS * rde_pkg::CHUNK_BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int CW    = $clog2(VALUE_WIDTH + 1);
  localparam int SIW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int OCW   = $clog2(rde_pkg::OUT_DEPTH + 1);

  rde_pkg::back_state_t state, state_next;

  logic [PADW-1:0]                  work;
  logic [rde_pkg::DIGIT_W-1:0]      rem;
  logic [SW-1:0]                    step;
  logic [CW-1:0]                    count;
  logic [CW-1:0]                    rd_left;
  logic                             rd_pending;
  logic                             rd_last;

  logic [PADW-1:0]                  work_next;
  logic [rde_pkg::DIGIT_W-1:0]      rem_next;
  logic                             last_step;
  logic                             quot_zero;
  logic                             room;
  logic                             digit_we;
  logic                             rd_issue;
  logic [CW-1:0]                    rd_prev;
  logic [rde_pkg::DIGIT_W-1:0]      ram_q;

  // One chunk of restoring division; remainder stays below the radix
  always_comb begin
    logic [rde_pkg::DIGIT_W:0]           r5;
    logic [rde_pkg::DIGIT_W-1:0]         r4;
    logic [rde_pkg::CHUNK_BITS-1:0]      qb;
    r4 = rem;
    qb = '0;
    for (int i = 0; i < rde_pkg::CHUNK_BITS; i++) begin
      r5 = {r4, work[PADW-1-i]};
      if (r5 >= radix) begin
        qb[rde_pkg::CHUNK_BITS-1-i] = 1'b1;
        r4 = rde_pkg::DIGIT_W'(r5 - radix);
      end else begin
        r4 = r5[rde_pkg::DIGIT_W-1:0];
      end
    end
    rem_next  = r4;
    work_next = (work << rde_pkg::CHUNK_BITS) | PADW'(qb);
  end

  assign last_step = (step == SW'(STEPS - 1));
  assign quot_zero = (work_next == '0);
  assign rd_prev   = rd_left - CW'(1);
  // Slots already committed in the result queue: stored, in flight, new
  assign room      = ({1'b0, out_count} + (OCW+1)'(rd_pending)) < (OCW+1)'(rde_pkg::OUT_DEPTH);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rde_pkg::ST_IDLE: begin
        if (item_valid) state_next = rde_pkg::ST_DIV;
      end
      rde_pkg::ST_DIV: begin
        if (last_step && quot_zero) state_next = rde_pkg::ST_EMIT;
      end
      rde_pkg::ST_EMIT: begin
        if (room && rd_left == CW'(1)) state_next = rde_pkg::ST_IDLE;
      end
      default: state_next = rde_pkg::ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    item_pop = 1'b0;
    digit_we = 1'b0;
    rd_issue = 1'b0;
    case (state)
      rde_pkg::ST_IDLE: item_pop = item_valid;
      rde_pkg::ST_DIV:  digit_we = last_step;
      rde_pkg::ST_EMIT: rd_issue = room;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= rde_pkg::ST_IDLE;
      step       <= '0;
      count      <= '0;
      rd_left    <= '0;
      rd_pending <= 1'b0;
      rem        <= '0;
      work       <= '0;
    end else begin
      state      <= state_next;
      rd_pending <= rd_issue;
      if (item_pop) begin
        work  <= PADW'(item_value);
        rem   <= '0;
        step  <= '0;
        count <= '0;
      end else if (state == rde_pkg::ST_DIV) begin
        work <= work_next;
        if (last_step) begin
          rem     <= '0;
          step    <= '0;
          count   <= count + CW'(1);
          rd_left <= count + CW'(1);
        end else begin
          rem  <= rem_next;
          step <= step + SW'(1);
        end
      end
      if (rd_issue) begin
        rd_left <= rd_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_last <= (rd_left == CW'(1));
  end

  rde_ram #(
    .WIDTH (rde_pkg::DIGIT_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (digit_we),
    .waddr (count[AW-1:0]),
    .wdata (rem_next),
    .raddr (rd_prev[AW-1:0]),
    .rdata (ram_q)
  );

  // Digit never reaches the radix, so the table index stays in range
  assign out_push        = rd_pending;
  assign out_item.last   = rd_last;
  assign out_item.symbol = sym_tab[ram_q[SIW-1:0]];

endmodule

// ===== rtl/core/radix_digit_emitter.sv =====
// ----------------------------------------------------------------------------
// radix_digit_emitter: integer to radix symbol stream
// Converts each value to digits of the configured radix and streams one
// symbol byte per digit, most significant first, tlast on the final digit.
// ----------------------------------------------------------------------------
// Flow: each value is registered into the input queue, divided by the radix once
//   per digit in the divider, then read back from the digit RAM into the result queue.
// Throughput: set by the single 8-bit-per-cycle divider, which takes a new value
//   only after the last digit of the previous one has been issued for read-back.
// Reset: rst clears queues and sequencer; radix 10, symbol table zero.
//   The digit RAM is not cleared and needs no clearing pass.
module radix_digit_emitter #(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [63:0]                       s_tdata,   // [63:0] value_bits
  input  logic [0:0]                        s_tuser,   // [0] is_signed
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [7:0]                        m_tdata,   // [7:0] symbol
  output logic                              m_tlast,   // last_digit
  // Configuration writes
  input  logic                              cfg_we,
  input  logic [rde_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [rde_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int ICW = $clog2(rde_pkg::IN_DEPTH + 1);
  localparam int OCW = $clog2(rde_pkg::OUT_DEPTH + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [rde_pkg::RADIX_W-1:0]  base_length;
  logic [rde_pkg::RADIX_W-1:0]  radix;
  logic [rde_pkg::SYMBOL_W-1:0] sym_tab [MAX_SYMBOLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length <= rde_pkg::RADIX_RESET;
    end else if (cfg_we) begin
      case (rde_pkg::cfg_index_t'(cfg_index))
        rde_pkg::CFG_BASE_LENGTH: base_length <= cfg_data[rde_pkg::RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Only the table entries the radix can reach are stored
  for (genvar b = 0; b < MAX_SYMBOLS; b++) begin : g_sym
    if (b < 8) begin : g_low
      always_ff @(posedge clk) begin
        if (rst) begin
          sym_tab[b] <= '0;
        end else if (cfg_we && cfg_index == rde_pkg::CFG_SYMBOLS_LOW) begin
          sym_tab[b] <= cfg_data[b*8 +: 8];
        end
      end
    end else begin : g_high
      always_ff @(posedge clk) begin
        if (rst) begin
          sym_tab[b] <= '0;
        end else if (cfg_we && cfg_index == rde_pkg::CFG_SYMBOLS_HIGH) begin
          sym_tab[b] <= cfg_data[(b-8)*8 +: 8];
        end
      end
    end
  end

  // Radix below two acts as two, above the table as the table size
  always_comb begin
    if (base_length < rde_pkg::RADIX_MIN) begin
      radix = rde_pkg::RADIX_MIN;
    end else if (base_length > rde_pkg::RADIX_W'(MAX_SYMBOLS)) begin
      radix = rde_pkg::RADIX_W'(MAX_SYMBOLS);
    end else begin
      radix = base_length;
    end
  end

  // --------------------------------------------------------------------------
  // Front: magnitude into the input queue
  // --------------------------------------------------------------------------
  logic                   in_push;
  logic [VALUE_WIDTH-1:0] in_push_data;
  logic                   in_full;
  logic                   in_empty;
  logic [ICW-1:0]         in_count;
  logic                   in_pop;
  logic [VALUE_WIDTH-1:0] in_head;

  rde_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_valid  (s_tvalid),
    .in_value  (s_tdata),
    .in_signed (s_tuser[0]),
    .q_full    (in_full),
    .in_ready  (s_tready),
    .q_push    (in_push),
    .q_data    (in_push_data)
  );

  rde_fifo #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (rde_pkg::IN_DEPTH)
  ) u_in_q (
    .clk       (clk),
    .rst       (rst),
    .push      (in_push),
    .push_data (in_push_data),
    .pop       (in_pop),
    .pop_data  (in_head),
    .full      (in_full),
    .empty     (in_empty),
    .count     (in_count)
  );

  // --------------------------------------------------------------------------
  // Back: divider, digit RAM, read-back into the result queue
  // --------------------------------------------------------------------------
  logic               out_push;
  rde_pkg::out_item_t out_push_item;
  logic               out_pop;
  rde_pkg::out_item_t out_head;
  logic               out_full;
  logic               out_empty;
  logic [OCW-1:0]     out_count;

  rde_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .radix      (radix),
    .sym_tab    (sym_tab),
    .item_valid (!in_empty),
    .item_value (in_head),
    .item_pop   (in_pop),
    .out_count  (out_count),
    .out_push   (out_push),
    .out_item   (out_push_item)
  );

  rde_fifo #(
    .WIDTH ($bits(rde_pkg::out_item_t)),
    .DEPTH (rde_pkg::OUT_DEPTH)
  ) u_out_q (
    .clk       (clk),
    .rst       (rst),
    .push      (out_push),
    .push_data (out_push_item),
    .pop       (out_pop),
    .pop_data  (out_head),
    .full      (out_full),
    .empty     (out_empty),
    .count     (out_count)
  );

  assign m_tvalid = !out_empty;
  assign m_tdata  = out_head.symbol;
  assign m_tlast  = out_head.last;
  assign out_pop  = m_tvalid && m_tready;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Read-back credit check must never overrun the result queue
  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(out_push && out_full && !out_pop))
    else $error("result queue overflow");

  // Front only pushes when the queue has room
  a_in_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(in_push && in_full))
    else $error("input queue overflow");

  // Occupancy never exceeds queue depth
  a_in_count: assert property (@(posedge clk) disable iff (rst)
    in_count <= ICW'(rde_pkg::IN_DEPTH))
    else $error("input queue count out of range");

  // No stale results survive reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

// ===== test/radix_digit_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radix_digit_checker: result predictor and scoreboard for the digit emitter
// Tracks register writes, converts every accepted value into its expected
// symbol stream and compares each result transfer in order.
// ----------------------------------------------------------------------------
module radix_digit_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [63:0]                     s_tdata,   // [63:0] value_bits
  input  logic [0:0]                      s_tuser,   // [0] is_signed
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [7:0]                      m_tdata,   // [7:0] symbol
  input  logic                            m_tlast,   // last_digit
  input  logic                            cfg_we,
  input  logic [rde_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rde_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              expected_left,
  output int                              fail_count
);

  localparam int MAX_RADIX = 16;

  logic [rde_pkg::RADIX_W-1:0] radix_reg;
  logic [63:0]                 sym_lo;
  logic [63:0]                 sym_hi;
  rde_pkg::out_item_t          symbol_q[$];
  int                          errors = 0;
  int                          result_no = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $time, result_no, msg);
    errors++;
  endtask

  function automatic logic [rde_pkg::SYMBOL_W-1:0] symbol_for(
    input logic [rde_pkg::DIGIT_W-1:0] d
  );
    if (d < 8)
      return sym_lo[8*d +: 8];
    return sym_hi[8*(d-8) +: 8];
  endfunction

  // Repeated division of the magnitude; digits come out LSB first and are
  // queued MSB first, tlast on the units digit.
  task automatic queue_digits(input logic [63:0] raw, input logic sgn);
    logic [63:0]                 mag;
    logic [63:0]                 radix;
    logic [rde_pkg::DIGIT_W-1:0] digits[64];
    int                          n;
    rde_pkg::out_item_t          item;
    radix = 64'(radix_reg);
    if (radix < 2)
      radix = 2;
    if (radix > MAX_RADIX)
      radix = MAX_RADIX;
    mag = (sgn && raw[63]) ? -raw : raw;
    n = 0;
    do begin
      digits[n] = rde_pkg::DIGIT_W'(mag % radix);
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < 64);
    for (int k = n - 1; k >= 0; k--) begin
      item.symbol = symbol_for(digits[k]);
      item.last   = (k == 0);
      symbol_q.push_back(item);
    end
  endtask

  always @(posedge clk) begin : watch
    rde_pkg::out_item_t want;
    if (rst) begin
      radix_reg = rde_pkg::RADIX_RESET;
      sym_lo    = '0;
      sym_hi    = '0;
      symbol_q.delete();
    end else begin
      if (cfg_we) begin
        case (rde_pkg::cfg_index_t'(cfg_index))
          rde_pkg::CFG_BASE_LENGTH:  radix_reg = cfg_data[rde_pkg::RADIX_W-1:0];
          rde_pkg::CFG_SYMBOLS_LOW:  sym_lo = cfg_data;
          rde_pkg::CFG_SYMBOLS_HIGH: sym_hi = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        queue_digits(s_tdata, s_tuser[0]);
      if (m_tvalid && m_tready) begin
        if (symbol_q.size() == 0) begin
          report_mismatch($sformatf("unexpected symbol %02h last %b", m_tdata, m_tlast));
        end else begin
          want = symbol_q.pop_front();
          if (m_tdata !== want.symbol)
            report_mismatch($sformatf("symbol %02h, want %02h", m_tdata, want.symbol));
          if (m_tlast !== want.last)
            report_mismatch($sformatf("tlast %b, want %b", m_tlast, want.last));
        end
        result_no++;
      end
    end
    expected_left <= symbol_q.size();
    fail_count    <= errors;
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top level for the radix digit emitter
// Drives values and register settings with random idle gaps and result
// back-pressure; the checker predicts and compares every symbol transfer.
// ----------------------------------------------------------------------------
module testbench;

  // Symbol tables: ASCII hex digits, digit 0 in the low byte
  localparam logic [63:0] HEX_LO   = "76543210";
  localparam logic [63:0] HEX_HI   = "fedcba98";
  localparam logic [63:0] MOST_NEG = 64'h8000_0000_0000_0000;
  localparam logic [63:0] ALL_ONES = '1;

  logic                            clk = 1'b0;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  logic [63:0]                     s_tdata;   // [63:0] value_bits
  logic [0:0]                      s_tuser;   // [0] is_signed
  logic                            m_tvalid;
  logic                            m_tready;
  logic [7:0]                      m_tdata;   // [7:0] symbol
  logic                            m_tlast;   // last_digit
  logic                            cfg_we;
  logic [rde_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [rde_pkg::CFG_DATA_W-1:0]  cfg_data;

  int  expected_left;
  int  fail_count;
  bit  steady;   // no idling on either side while set

  always #4 clk = ~clk;

  radix_digit_emitter DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  radix_digit_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .expected_left (expected_left),
    .fail_count    (fail_count)
  );

  // Idle length: mostly none, often short, now and then long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60)
      return 0;
    if (r < 95)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Value mix: small numbers, leading zeros, near the sign boundary,
  // near all ones, and full 64-bit noise
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 99));
      1: v = v >> $urandom_range(1, 63);
      2: v = MOST_NEG | (v & 64'hFF);
      3: v = ~(v & 64'hFF);
      default: ;
    endcase
    return v;
  endfunction

  // Result side: random stalls on tready, none while steady
  initial begin : result_sink
    int stall;
    stall = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (steady) begin
        m_tready <= 1'b1;
      end else if (stall > 0) begin
        m_tready <= 1'b0;
        stall--;
      end else begin
        stall = idle_length();
        m_tready <= (stall == 0);
        if (stall > 0)
          stall--;
      end
    end
  end

  // One input transfer; tvalid stays high into the next call when no gap
  task automatic send_value(input logic [63:0] v, input logic sgn);
    int gap;
    gap = steady ? 0 : idle_length();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= sgn;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Hold the input off until every expected symbol has gone out
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  // Three back-to-back register writes; only while idle
  task automatic load_config(input logic [63:0] radix_word, input logic [63:0] lo,
                             input logic [63:0] hi);
    cfg_we    <= 1'b1;
    cfg_index <= rde_pkg::CFG_BASE_LENGTH;
    cfg_data  <= radix_word;
    @(posedge clk);
    cfg_index <= rde_pkg::CFG_SYMBOLS_LOW;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= rde_pkg::CFG_SYMBOLS_HIGH;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random radix word: upper bits noise, low five bits biased to the edges
  task automatic random_config();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       r[4:0] = 5'($urandom_range(0, 1));
      1:       r[4:0] = 5'($urandom_range(17, 31));
      2:       r[4:0] = 5'd16;
      3:       r[4:0] = 5'd2;
      default: r[4:0] = 5'($urandom_range(3, 15));
    endcase
    load_config(r, {$urandom, $urandom}, {$urandom, $urandom});
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= rde_pkg::CFG_BASE_LENGTH;
    cfg_data  <= '0;
    steady    <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: radix 10, every symbol zero
    send_value(64'd0, 1'b0);
    send_value(ALL_ONES, 1'b0);
    send_value(ALL_ONES, 1'b1);          // -1 gives the single digit 1
    drain();

    // Hex with readable symbols
    load_config(64'd16, HEX_LO, HEX_HI);
    send_value(64'd0, 1'b0);
    send_value(ALL_ONES, 1'b0);
    send_value(MOST_NEG, 1'b1);          // most negative, exact magnitude
    send_value(MOST_NEG, 1'b0);
    send_value(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_value(64'h0123_4567_89AB_CDEF, 1'b1);
    drain();

    // Radix below two acts as binary: results of up to 64 digits
    load_config(64'd0, HEX_LO, HEX_HI);
    send_value(ALL_ONES, 1'b0);
    send_value(MOST_NEG, 1'b1);
    send_value(64'd1, 1'b0);
    drain();

    load_config(64'd1, ALL_ONES, 64'd0);
    send_value(64'd5, 1'b0);
    drain();

    // Radix above the table clamps to 16
    load_config(64'd31, 64'd0, ALL_ONES);
    send_value(64'hFEDC_BA98_7654_3210, 1'b0);
    drain();

    // Upper bits of the radix word are ignored; low bits give 17
    load_config(64'hFFFF_FFFF_FFFF_FFF1, HEX_LO, HEX_HI);
    send_value(64'hA5A5_A5A5_A5A5_A5A5, 1'b1);
    drain();

    load_config(64'd10, HEX_LO, HEX_HI);
    send_value(MOST_NEG, 1'b1);
    send_value(-64'd12345, 1'b1);
    send_value(64'd10000000000000000000, 1'b0);
    drain();

    // Random phases, each under fresh settings; the third runs without idling
    for (int phase = 0; phase < 6; phase++) begin
      steady <= (phase == 2);
      random_config();
      repeat (15) send_value(random_value(), 1'($urandom_range(0, 1)));
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #20_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule
